// ===== hw/rtl/tpo_pkg.sv =====
package tpo_pkg;

    localparam int HOLES_DEF            = 2;
    localparam int CORNERS_PER_HOLE_DEF = 4;
    localparam int COORD_BITS_DEF       = 16;
    localparam int HOLE_REGS            = 2;
    localparam int CFG_IDX_BITS         = 3;
    localparam int CFG_DATA_BITS        = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_RELEVANT_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLE_A_CORNERS_LOW  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLE_A_CORNERS_HIGH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLE_B_CORNERS_LOW  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLE_B_CORNERS_HIGH = 3'd4;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] x_a;
        logic [15:0] y_a;
        logic [15:0] x_b;
        logic [15:0] y_b;
        logic [15:0] x_c;
        logic [15:0] y_c;
        logic [15:0] id_a;
        logic [15:0] id_b;
        logic [15:0] id_c;
    } item_t;

    typedef struct packed {
        logic visible;
        logic too_far;
        logic occluded;
    } result_t;

    // Candidate job passed from front to back: reference triangle as seen at accept,
    // candidate coordinates, ids and distance verdict
    typedef struct packed {
        logic        far;
        logic [47:0] ref_x;
        logic [47:0] ref_y;
        logic [47:0] ref_id;
        logic [15:0] x_a;
        logic [15:0] y_a;
        logic [15:0] x_b;
        logic [15:0] y_b;
        logic [15:0] x_c;
        logic [15:0] y_c;
        logic [15:0] id_a;
        logic [15:0] id_b;
        logic [15:0] id_c;
    } job_t;

endpackage

// ===== hw/rtl/tpo_item_if.sv =====
interface tpo_item_if;
    logic              valid;
    logic              ready;
    tpo_pkg::item_t    data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tpo_result_if.sv =====
interface tpo_result_if;
    logic              valid;
    logic              ready;
    tpo_pkg::result_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tpo_front.sv =====
// Front: store reference triangle, run the centroid distance check, queue a job
module tpo_front #(
    parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tpo_pkg::item_t      in_data,
    input  logic [15:0]         relevant_distance,
    output logic                job_valid,
    input  logic                job_ready,
    output tpo_pkg::job_t       job_data
);
    localparam int SB = COORD_BITS + 3;        // sum and difference width
    localparam int PB = 2 * SB;                // square width

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [47:0] ref_x_reg, ref_y_reg, ref_id_reg;
    tpo_pkg::job_t job_reg;
    logic signed [SB-1:0] dsx_reg, dsy_reg;
    logic [PB-1:0] sqx_reg, sqy_reg;
    logic [35:0]   lim_reg;

    function automatic logic signed [SB-1:0] sx(input logic [15:0] v);
        return SB'($signed(v[COORD_BITS-1:0]));
    endfunction

    logic accept;
    logic [33:0] rd_sq;
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign rd_sq    = 34'(relevant_distance) * 34'(relevant_distance);

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept && in_data.op == tpo_pkg::OP_TEST) state_next = ST_SQ;
            ST_SQ:   state_next = ST_CMP;
            ST_CMP:  state_next = ST_OUT;
            ST_OUT:  if (job_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ref_x_reg  <= '0;
            ref_y_reg  <= '0;
            ref_id_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && in_data.op == tpo_pkg::OP_STORE)
            begin
                ref_x_reg  <= {in_data.x_c, in_data.x_b, in_data.x_a};
                ref_y_reg  <= {in_data.y_c, in_data.y_b, in_data.y_a};
                ref_id_reg <= {in_data.id_c, in_data.id_b, in_data.id_a};
            end
        end
    end

    // Datapath: difference of sums, then squares, then compare
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    job_reg.far    <= 1'b0;
                    job_reg.ref_x  <= ref_x_reg;
                    job_reg.ref_y  <= ref_y_reg;
                    job_reg.ref_id <= ref_id_reg;
                    job_reg.x_a  <= in_data.x_a;
                    job_reg.y_a  <= in_data.y_a;
                    job_reg.x_b  <= in_data.x_b;
                    job_reg.y_b  <= in_data.y_b;
                    job_reg.x_c  <= in_data.x_c;
                    job_reg.y_c  <= in_data.y_c;
                    job_reg.id_a <= in_data.id_a;
                    job_reg.id_b <= in_data.id_b;
                    job_reg.id_c <= in_data.id_c;
                    dsx_reg <= (sx(ref_x_reg[15:0]) + sx(ref_x_reg[31:16])
                                + sx(ref_x_reg[47:32]))
                             - (sx(in_data.x_a) + sx(in_data.x_b) + sx(in_data.x_c));
                    dsy_reg <= (sx(ref_y_reg[15:0]) + sx(ref_y_reg[31:16])
                                + sx(ref_y_reg[47:32]))
                             - (sx(in_data.y_a) + sx(in_data.y_b) + sx(in_data.y_c));
                    lim_reg <= 36'(rd_sq) * 36'd9;
                end
            end
            ST_SQ:
            begin
                sqx_reg <= PB'(dsx_reg * dsx_reg);
                sqy_reg <= PB'(dsy_reg * dsy_reg);
            end
            ST_CMP:
            begin
                job_reg.far <= ((PB+1)'(sqx_reg) + (PB+1)'(sqy_reg)) > (PB+1)'(lim_reg);
            end
            default: ;
        endcase
    end

    assign job_valid = (state_reg == ST_OUT);
    assign job_data  = job_reg;
endmodule

// ===== hw/rtl/tpo_queue.sv =====
// Two-entry job queue between front and back
module tpo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  tpo_pkg::job_t  wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output tpo_pkg::job_t  rd_data
);
    tpo_pkg::job_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== hw/rtl/tpo_back.sv =====
// Back: one shared segment-crossing unit steps over holes, segments and edges
module tpo_back #(
    parameter int HOLES            = tpo_pkg::HOLES_DEF,
    parameter int CORNERS_PER_HOLE = tpo_pkg::CORNERS_PER_HOLE_DEF,
    parameter int COORD_BITS       = tpo_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    output logic                 job_ready,
    input  tpo_pkg::job_t        job_data,
    input  logic [4*64-1:0]      hole_words,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tpo_pkg::result_t     res_data
);
    localparam int DB = COORD_BITS + 1;      // coordinate difference
    localparam int XB = 2 * DB + 1;          // cross product
    localparam int NH = (HOLES < tpo_pkg::HOLE_REGS) ? HOLES : tpo_pkg::HOLE_REGS;
    localparam int HB = (NH > 1) ? $clog2(NH) : 1;
    localparam int EB = $clog2(CORNERS_PER_HOLE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]    state_reg;
    tpo_pkg::job_t job_reg;
    logic [HB-1:0] h_reg;
    logic [1:0]    i_reg, j_reg;
    logic [EB-1:0] e_reg;
    logic          hit_reg;      // current segment has crossed an edge
    logic          all_reg;      // declared but never assigned or read
    logic          occ_reg;
    tpo_pkg::result_t res_reg;

    function automatic logic signed [DB-1:0] sx(input logic [15:0] v);
        return DB'($signed(v[COORD_BITS-1:0]));
    endfunction

    function automatic logic [15:0] corner_x(input logic [4*64-1:0] hw,
                                             input logic [HB-1:0] h, input logic [EB-1:0] c);
        logic [63:0] w;
        w = hw[(2*32'(h) + ((32'(c) >> 1) & 1))*64 +: 64];
        return (c[0]) ? w[47:32] : w[15:0];
    endfunction

    function automatic logic [15:0] corner_y(input logic [4*64-1:0] hw,
                                             input logic [HB-1:0] h, input logic [EB-1:0] c);
        logic [63:0] w;
        w = hw[(2*32'(h) + ((32'(c) >> 1) & 1))*64 +: 64];
        return (c[0]) ? w[63:48] : w[31:16];
    endfunction

    function automatic logic signed [1:0] sgn(input logic signed [XB-1:0] v);
        return (v > 0) ? 2'sd1 : ((v < 0) ? -2'sd1 : 2'sd0);
    endfunction

    // Select the current segment and edge and test them for a crossing
    logic [EB-1:0] e_nx;
    logic [15:0] cand_x, cand_y, cand_id;
    logic signed [DB-1:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic same_id, bbox_ok, cross_ok, seg_hit;
    logic signed [XB-1:0] c1, c2, c3, c4;
    logic signed [1:0] s1a, s1b, s2a, s2b;

    always_comb
    begin
        e_nx = (32'(e_reg) == CORNERS_PER_HOLE - 1) ? '0 : e_reg + 1'b1;
        case (j_reg)
            2'd0:    begin cand_x = job_reg.x_a; cand_y = job_reg.y_a; cand_id = job_reg.id_a; end
            2'd1:    begin cand_x = job_reg.x_b; cand_y = job_reg.y_b; cand_id = job_reg.id_b; end
            default: begin cand_x = job_reg.x_c; cand_y = job_reg.y_c; cand_id = job_reg.id_c; end
        endcase
        ax = sx(job_reg.ref_x[16*i_reg +: 16]);
        ay = sx(job_reg.ref_y[16*i_reg +: 16]);
        bx = sx(cand_x);
        by = sx(cand_y);
        cx = sx(corner_x(hole_words, h_reg, e_reg));
        cy = sx(corner_y(hole_words, h_reg, e_reg));
        dx = sx(corner_x(hole_words, h_reg, e_nx));
        dy = sx(corner_y(hole_words, h_reg, e_nx));
        same_id = (job_reg.ref_id[16*i_reg +: 16] == cand_id);
        bbox_ok = !(((ax < bx) ? ax : bx) > ((cx > dx) ? cx : dx) ||
                    ((cx < dx) ? cx : dx) > ((ax > bx) ? ax : bx) ||
                    ((ay < by) ? ay : by) > ((cy > dy) ? cy : dy) ||
                    ((cy < dy) ? cy : dy) > ((ay > by) ? ay : by));
        c1 = XB'((ax - cx) * (dy - cy)) - XB'((ay - cy) * (dx - cx));
        c2 = XB'((dx - cx) * (by - cy)) - XB'((dy - cy) * (bx - cx));
        c3 = XB'((cx - bx) * (ay - by)) - XB'((cy - by) * (ax - bx));
        c4 = XB'((ax - bx) * (dy - by)) - XB'((ay - by) * (dx - bx));
        s1a = sgn(c1); s1b = sgn(c2); s2a = sgn(c3); s2b = sgn(c4);
        cross_ok = !((s1a * s1b) < 0) && !((s2a * s2b) < 0);
        seg_hit  = !same_id && bbox_ok && cross_ok;
    end

    logic last_edge, seg_done, seg_ok, last_seg, last_hole;
    assign last_edge = (32'(e_reg) == CORNERS_PER_HOLE - 1);
    assign seg_ok    = hit_reg || seg_hit;
    assign seg_done  = seg_ok || last_edge || same_id;
    assign last_seg  = (i_reg == 2'd2) && (j_reg == 2'd2);
    assign last_hole = (32'(h_reg) == NH - 1);

    assign job_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res_data  = res_reg;

    // Step one edge test per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (job_valid)
                        state_reg <= job_data.far ? ST_OUT : ST_RUN;
                ST_RUN:
                    if (seg_done && (!(seg_ok && !same_id) || last_seg) && last_hole)
                        state_reg <= ST_OUT;
                    else if (seg_done && seg_ok && !same_id && last_seg)
                        state_reg <= ST_OUT;
                ST_OUT:
                    if (res_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg <= job_data;
                h_reg   <= '0;
                i_reg   <= 2'd0;
                j_reg   <= 2'd0;
                e_reg   <= '0;
                hit_reg <= 1'b0;
                res_reg <= '{visible: 1'b0, too_far: 1'b1, occluded: 1'b0};
            end
            ST_RUN:
            begin
                if (!seg_done)
                begin
                    e_reg   <= e_nx;
                    hit_reg <= seg_ok;
                end
                else if (seg_ok && !same_id && !last_seg)
                begin
                    // segment crossed: next segment of this hole
                    e_reg   <= '0;
                    hit_reg <= 1'b0;
                    if (j_reg == 2'd2) begin j_reg <= 2'd0; i_reg <= i_reg + 2'd1; end
                    else j_reg <= j_reg + 2'd1;
                end
                else if (seg_ok && !same_id)
                begin
                    // all nine crossed: occluded
                    res_reg <= '{visible: 1'b0, too_far: 1'b0, occluded: 1'b1};
                end
                else
                begin
                    // hole fails: next hole or visible
                    e_reg   <= '0;
                    hit_reg <= 1'b0;
                    i_reg   <= 2'd0;
                    j_reg   <= 2'd0;
                    h_reg   <= h_reg + 1'b1;
                    res_reg <= '{visible: 1'b1, too_far: 1'b0, occluded: 1'b0};
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/triangle_pair_occlusion_test_core.sv =====
// A store transaction updates the reference triangle and gives no result; a test
// result is offered after the front states (sum, square, compare, offer), the queue,
// the back accept and up to HOLES*9*CORNERS_PER_HOLE (72 by default) edge tests.
// The single edge-test unit takes no new test until its last result is taken;
// the two-entry queue lets the front run ahead.
// Reset: rst_n clears reference triangle, configuration registers and control state.
module triangle_pair_occlusion_test_core #(
    parameter int HOLES            = tpo_pkg::HOLES_DEF,
    parameter int CORNERS_PER_HOLE = tpo_pkg::CORNERS_PER_HOLE_DEF,
    parameter int COORD_BITS       = tpo_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tpo_item_if.sink                           in_item,
    tpo_result_if.source                       out_result,
    input  logic                               cfg_we,
    input  logic [tpo_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tpo_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    logic [15:0]    relevant_distance_reg;
    logic [4*64-1:0] hole_words_reg;
    logic           f_valid, f_ready, b_valid, b_ready;
    tpo_pkg::job_t  f_data, b_data;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relevant_distance_reg <= '0;
            hole_words_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpo_pkg::REG_RELEVANT_DISTANCE:   relevant_distance_reg <= cfg_data[15:0];
                tpo_pkg::REG_HOLE_A_CORNERS_LOW:  hole_words_reg[63:0]    <= cfg_data;
                tpo_pkg::REG_HOLE_A_CORNERS_HIGH: hole_words_reg[127:64]  <= cfg_data;
                tpo_pkg::REG_HOLE_B_CORNERS_LOW:  hole_words_reg[191:128] <= cfg_data;
                tpo_pkg::REG_HOLE_B_CORNERS_HIGH: hole_words_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    tpo_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_item.valid), .in_ready(in_item.ready), .in_data(in_item.data),
        .relevant_distance(relevant_distance_reg),
        .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
    );

    tpo_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    tpo_back #(
        .HOLES(HOLES), .CORNERS_PER_HOLE(CORNERS_PER_HOLE), .COORD_BITS(COORD_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(b_valid), .job_ready(b_ready), .job_data(b_data),
        .hole_words(hole_words_reg),
        .res_valid(out_result.valid), .res_ready(out_result.ready),
        .res_data(out_result.data)
    );
endmodule
